@@ hdl/olsu_pkg.sv @@
package olsu_pkg;

   // Command codes carried in req_tuser
   typedef enum logic [2:0] {
      CMD_APPEND         = 3'd0,
      CMD_INSERT_BEFORE  = 3'd1,
      CMD_INSERT_AFTER   = 3'd2,
      CMD_REMOVE_FAST    = 3'd3,
      CMD_REMOVE_ORDERED = 3'd4,
      CMD_GET            = 3'd5,
      CMD_CLEAR          = 3'd6
   } cmd_type;

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_FULL  = 2'd1,
      ST_RANGE = 2'd2
   } status_type;

   // Operation broadcast to every cell of the row
   typedef enum logic [1:0] {
      CELL_HOLD           = 2'd0,
      CELL_INSERT         = 2'd1,
      CELL_REMOVE_FAST    = 2'd2,
      CELL_REMOVE_ORDERED = 2'd3
   } cell_op_type;

   localparam int unsigned CMD_WIDTH    = 3;
   localparam int unsigned INDEX_WIDTH  = 6;
   localparam int unsigned VALUE_WIDTH  = 32;
   localparam int unsigned TOTAL_WIDTH  = 7;
   localparam int unsigned STATUS_WIDTH = 2;

endpackage

@@ hdl/olsu_cell.sv @@
module olsu_cell
   import olsu_pkg::*;
#(
   parameter int unsigned POS          = 0,
   parameter int unsigned IDX_WIDTH    = 6,
   parameter int unsigned HANDLE_WIDTH = 32
) (
   input  logic                    clock,
   input  cell_op_type             op,
   input  logic [IDX_WIDTH-1:0]    op_pos,
   input  logic [IDX_WIDTH-1:0]    rd_pos,
   input  logic [IDX_WIDTH-1:0]    tail_pos,
   input  logic [HANDLE_WIDTH-1:0] value,
   input  logic [HANDLE_WIDTH-1:0] tail,
   input  logic [HANDLE_WIDTH-1:0] below,
   input  logic [HANDLE_WIDTH-1:0] above,
   output logic [HANDLE_WIDTH-1:0] data,
   output logic [HANDLE_WIDTH-1:0] rd_tap,
   output logic [HANDLE_WIDTH-1:0] tail_tap
);

   localparam logic [IDX_WIDTH-1:0] MyPos = IDX_WIDTH'(POS);

   logic [HANDLE_WIDTH-1:0] data_ff;
   logic [HANDLE_WIDTH-1:0] data_in;
   logic                    at_pos;
   logic                    past_pos;

   assign at_pos   = (MyPos == op_pos);
   assign past_pos = (MyPos > op_pos);

   always_comb begin
      data_in = data_ff;
      case (op)
         CELL_INSERT: begin
            // open a hole at op_pos, shift later entries up
            if (at_pos) begin
               data_in = value;
            end else if (past_pos) begin
               data_in = below;
            end
         end
         CELL_REMOVE_FAST: begin
            if (at_pos) begin
               data_in = tail;
            end
         end
         CELL_REMOVE_ORDERED: begin
            if (at_pos || past_pos) begin
               data_in = above;
            end
         end
         default: begin
            data_in = data_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data     = data_ff;
   assign rd_tap   = (MyPos == rd_pos)   ? data_ff : '0;
   assign tail_tap = (MyPos == tail_pos) ? data_ff : '0;

endmodule

@@ hdl/ordered_list_store_unit.sv @@
// Ordered list of up to CAPACITY handles held in a row of cells, one entry per cell.
// Each request word carries a command in req_tuser (append, insert before, insert after,
// remove fast, remove ordered, get, clear) and index/value in req_tdata; each command
// returns exactly one response word with the value read, a found flag, the entry count
// after the command and a status (ok, full or index out of range).
// Every cell takes its next value from itself, its neighbors or the broadcast value in
// the same clock edge, so any command completes at that edge: one word is accepted per
// cycle unless a response waits unread, and its response is registered and held from
// the next cycle on. The cycle is set by the position compares in the cells and the
// select trees that gather the entry read by get and the last entry used by remove
// fast. Entries beyond the count are never read and need no clearing after reset.
module ordered_list_store_unit
   import olsu_pkg::*;
#(
   parameter int unsigned CAPACITY     = 64,
   parameter int unsigned HANDLE_WIDTH = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // index [5:0], value [37:6], zero fill [39:38]
   input  logic [2:0]  req_tuser,   // command [2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata    // read_value [31:0], found [32], entry_total [39:33],
                                    // status [41:40], zero fill [47:42]
);

   localparam int unsigned IdxW = $clog2(CAPACITY);
   localparam int unsigned CntW = $clog2(CAPACITY + 1);
   localparam int unsigned CmpW = (CntW > TOTAL_WIDTH) ? CntW : TOTAL_WIDTH;
   localparam logic [CntW-1:0] Cap = CntW'(CAPACITY);

   logic [INDEX_WIDTH-1:0]  req_index;
   logic [VALUE_WIDTH-1:0]  req_value;
   cmd_type                 req_cmd;
   logic                    req_fire;

   logic [CntW-1:0]         count_ff;
   logic [CntW-1:0]         count_in;
   logic [CntW-1:0]         count_dec;
   logic                    full;
   logic [CmpW-1:0]         idx_ext;
   logic [CmpW-1:0]         idx_inc;
   logic [CmpW-1:0]         cnt_ext;
   logic [CmpW-1:0]         total_ext;

   cell_op_type             op;
   logic [CmpW-1:0]         op_pos_ext;
   logic [IdxW-1:0]         op_pos;
   logic [IdxW-1:0]         rd_pos;
   logic [IdxW-1:0]         tail_pos;

   logic [HANDLE_WIDTH+VALUE_WIDTH-1:0] value_wide;
   logic [HANDLE_WIDTH-1:0] handle;
   logic [HANDLE_WIDTH-1:0] cell_q    [CAPACITY];
   logic [HANDLE_WIDTH-1:0] rd_tap    [CAPACITY];
   logic [HANDLE_WIDTH-1:0] tail_tap  [CAPACITY];
   logic [CAPACITY-1:0]     rd_col    [HANDLE_WIDTH];
   logic [CAPACITY-1:0]     tail_col  [HANDLE_WIDTH];
   logic [HANDLE_WIDTH-1:0] rd_word;
   logic [HANDLE_WIDTH-1:0] tail_word;
   logic [HANDLE_WIDTH+VALUE_WIDTH-1:0] rd_wide;

   logic                    found;
   status_type              status;

   logic                    rsp_valid_ff;
   logic [VALUE_WIDTH-1:0]  rd_value_ff;
   logic [VALUE_WIDTH-1:0]  rd_value_in;
   logic                    found_ff;
   logic [TOTAL_WIDTH-1:0]  total_ff;
   status_type              status_ff;

   assign req_index = req_tdata[INDEX_WIDTH-1:0];
   assign req_value = req_tdata[INDEX_WIDTH+VALUE_WIDTH-1:INDEX_WIDTH];
   assign req_cmd   = cmd_type'(req_tuser);

   // output register frees up in the cycle its word is taken
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_fire   = req_tvalid && req_tready;

   assign full      = (count_ff == Cap);
   assign count_dec = count_ff - 1'b1;
   assign idx_ext   = CmpW'(req_index);
   assign idx_inc   = idx_ext + 1'b1;
   assign cnt_ext   = CmpW'(count_ff);
   assign rd_pos    = idx_ext[IdxW-1:0];
   assign tail_pos  = count_dec[IdxW-1:0];
   assign op_pos    = op_pos_ext[IdxW-1:0];

   assign value_wide = {{HANDLE_WIDTH{1'b0}}, req_value};
   assign handle     = value_wide[HANDLE_WIDTH-1:0];

   always_comb begin
      op         = CELL_HOLD;
      op_pos_ext = idx_ext;
      count_in   = count_ff;
      status     = ST_OK;
      found      = 1'b0;
      case (req_cmd)
         CMD_APPEND: begin
            if (full) begin
               status = ST_FULL;
            end else begin
               op         = CELL_INSERT;
               op_pos_ext = cnt_ext;
               count_in   = count_ff + 1'b1;
            end
         end
         CMD_INSERT_BEFORE: begin
            if (idx_ext > cnt_ext) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               op       = CELL_INSERT;
               count_in = count_ff + 1'b1;
            end
         end
         CMD_INSERT_AFTER: begin
            if (idx_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else if (full) begin
               status = ST_FULL;
            end else begin
               op         = CELL_INSERT;
               op_pos_ext = idx_inc;
               count_in   = count_ff + 1'b1;
            end
         end
         CMD_REMOVE_FAST: begin
            if (idx_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               op       = CELL_REMOVE_FAST;
               count_in = count_dec;
            end
         end
         CMD_REMOVE_ORDERED: begin
            if (idx_ext >= cnt_ext) begin
               status = ST_RANGE;
            end else begin
               op       = CELL_REMOVE_ORDERED;
               count_in = count_dec;
            end
         end
         CMD_GET: begin
            if (idx_ext < cnt_ext) begin
               found = 1'b1;
            end else begin
               status = ST_RANGE;
            end
         end
         CMD_CLEAR: begin
            count_in = '0;
         end
         default: begin
            status = ST_RANGE;
         end
      endcase
      // drop the cell update unless the word is taken
      if (!req_fire) begin
         op = CELL_HOLD;
      end
   end

   genvar c, b;
   generate
      for (c = 0; c < CAPACITY; c++) begin : g_cell
         logic [HANDLE_WIDTH-1:0] below;
         logic [HANDLE_WIDTH-1:0] above;

         if (c == 0) begin : g_first
            assign below = cell_q[c];
         end else begin : g_below
            assign below = cell_q[c-1];
         end

         if (c == CAPACITY - 1) begin : g_last
            assign above = cell_q[c];
         end else begin : g_above
            assign above = cell_q[c+1];
         end

         olsu_cell #(
            .POS          (c),
            .IDX_WIDTH    (IdxW),
            .HANDLE_WIDTH (HANDLE_WIDTH)
         ) u_cell (
            .clock    (clock),
            .op       (op),
            .op_pos   (op_pos),
            .rd_pos   (rd_pos),
            .tail_pos (tail_pos),
            .value    (handle),
            .tail     (tail_word),
            .below    (below),
            .above    (above),
            .data     (cell_q[c]),
            .rd_tap   (rd_tap[c]),
            .tail_tap (tail_tap[c])
         );

         for (b = 0; b < HANDLE_WIDTH; b++) begin : g_col
            assign rd_col[b][c]   = rd_tap[c][b];
            assign tail_col[b][c] = tail_tap[c][b];
         end
      end

      // at most one cell drives each tap, so an OR gathers the selected entry
      for (b = 0; b < HANDLE_WIDTH; b++) begin : g_gather
         assign rd_word[b]   = |rd_col[b];
         assign tail_word[b] = |tail_col[b];
      end
   endgenerate

   assign rd_wide     = {{VALUE_WIDTH{1'b0}}, rd_word};
   assign rd_value_in = found ? rd_wide[VALUE_WIDTH-1:0] : '0;
   assign total_ext   = CmpW'(count_in);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_fire) begin
            count_ff <= count_in;
         end
         if (req_fire) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         rd_value_ff <= rd_value_in;
         found_ff    <= found;
         total_ff    <= total_ext[TOTAL_WIDTH-1:0];
         status_ff   <= status;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, status_ff, total_ff, found_ff, rd_value_ff};

endmodule
